/* src/ngga_pkg.sv */
// ngga_pkg: character codes, limits and small lookup functions for the gga position parser
package ngga_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SOUTH = 8'h53;
    localparam logic [7:0] CH_WEST  = 8'h57;

    localparam logic [4:0] FIELD_HEADER  = 5'd0;
    localparam logic [4:0] FIELD_LAT_NUM = 5'd2;
    localparam logic [4:0] FIELD_LAT_HEM = 5'd3;
    localparam logic [4:0] FIELD_LON_NUM = 5'd4;
    localparam logic [4:0] FIELD_LON_HEM = 5'd5;
    localparam logic [4:0] FIELD_MAX     = 5'd31;

    localparam logic [2:0] HEADER_LEN = 3'd6;
    localparam logic [2:0] HEADER_SAT = 3'd7;

    localparam logic [10:0] DEG_SAT = 11'd1310;
    localparam logic [6:0]  MIN_SAT = 7'd71;

    localparam logic [33:0] LAT_LIMIT = 34'd900000000;
    localparam logic [33:0] LON_LIMIT = 34'd1800000000;

    localparam logic [23:0] DEG_SCALE   = 24'd10000000;
    localparam logic [17:0] MIN_SCALE   = 18'd166666;
    localparam logic [23:0] DIV6_RECIP  = 24'd2796203;

    typedef struct packed {
        logic [10:0] deg;
        logic [6:0]  min;
        logic [19:0] frac;
        logic [2:0]  frac_cnt;
        logic        point;
        logic        stopped;
    } t_num;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] len;
    } t_hemi;

    typedef struct packed {
        logic [33:0] deg_e7;
        logic [24:0] min_e7;
        logic [17:0] rest_e7;
        logic        point;
        logic        neg;
        logic [7:0]  hemi;
    } t_coord;

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h24;
            3'd1: ch = 8'h47;
            3'd2: ch = 8'h50;
            3'd3: ch = 8'h47;
            3'd4: ch = 8'h47;
            3'd5: ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // weight of a fraction digit in 1e-6 minute units
    function automatic logic [19:0] frac_weight(input logic [2:0] cnt);
        logic [19:0] w;
        case (cnt)
            3'd0: w = 20'd100000;
            3'd1: w = 20'd10000;
            3'd2: w = 20'd1000;
            3'd3: w = 20'd100;
            3'd4: w = 20'd10;
            3'd5: w = 20'd1;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage

/* src/nmea_gga_position_parser_core.sv */
// nmea_gga_position_parser_core: byte-wise gga sentence parser with fixed-point coordinate output
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  in       | i_valid / o_ready  | i_byte_in
//  out      | o_valid / i_ready  | o_latitude_e7, o_longitude_e7, o_lat_hemisphere,
//           |                    | o_lon_hemisphere, o_lat_has_point, o_lon_has_point
//
// one byte per cycle while o_ready is high; digits are folded into degree/minute registers
// as they arrive; a line feed of a matching sentence yields a result through the product
// stage, then the output register; the product stage and output register form a two-deep queue
// o_ready drops only while both hold a word and i_ready is low
// i_rst_n is synchronous and clears the line state and both valid flags
module nmea_gga_position_parser_core
    import ngga_pkg::*;
#(
    parameter int FRAC_DIGITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [30:0] o_latitude_e7,
    output logic signed [31:0] o_longitude_e7,
    output logic [7:0]         o_lat_hemisphere,
    output logic [7:0]         o_lon_hemisphere,
    output logic               o_lat_has_point,
    output logic               o_lon_has_point
);

    localparam logic [2:0] FRAC_MAX = 3'(FRAC_DIGITS);

    logic [4:0] r_field, n_field;
    logic [2:0] r_hdr_cnt, n_hdr_cnt;
    logic       r_hdr_ok, n_hdr_ok;
    t_num       r_num [2];
    t_num       n_num [2];
    t_hemi      r_hemi [2];
    t_hemi      n_hemi [2];

    logic   r_p_valid;
    t_coord r_p [2];
    t_coord n_p [2];

    logic               r_out_valid;
    logic signed [30:0] r_lat;
    logic signed [31:0] r_lon;
    logic [7:0]         r_lat_hemi, r_lon_hemi;
    logic               r_lat_pt, r_lon_pt;

    logic out_free, p_free, accept, hit;

    function automatic t_num take_char(input t_num s, input logic [7:0] c);
        t_num        t;
        logic [3:0]  d;
        logic [9:0]  v;
        logic [3:0]  hi;
        logic [9:0]  lo;
        logic [13:0] q;
        t  = s;
        d  = c[3:0];
        v  = 10'({3'b0, s.min} * 10'd10) + 10'(d);
        hi = 4'd0;
        for (int j = 1; j <= 9; j++) begin
            if (v >= 10'(j * 100)) hi = 4'(j);
        end
        lo = v - 10'({6'b0, hi} * 10'd100);
        q  = 14'({3'b0, s.deg} * 14'd10) + 14'(hi);
        if (c == CH_POINT && !s.point) begin
            t.point = 1'b1;
        end else if (!s.stopped) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!s.point) begin
                    if (q > 14'(DEG_SAT) || (q == 14'(DEG_SAT) && lo > 10'(MIN_SAT))) begin
                        t.deg = DEG_SAT;
                        t.min = MIN_SAT;
                    end else begin
                        t.deg = q[10:0];
                        t.min = lo[6:0];
                    end
                end else if (s.frac_cnt < FRAC_MAX) begin
                    t.frac     = s.frac + 20'({16'b0, d} * frac_weight(s.frac_cnt));
                    t.frac_cnt = s.frac_cnt + 3'd1;
                end
            end else begin
                t.stopped = 1'b1;
            end
        end
        return t;
    endfunction

    function automatic t_hemi take_hemi(input t_hemi s, input logic [7:0] c);
        t_hemi t;
        t = s;
        if (s.len == 2'd0) t.ch = c;
        if (s.len != 2'd3) t.len = s.len + 2'd1;
        return t;
    endfunction

    function automatic t_coord make_coord(input t_num s, input t_hemi h, input logic [7:0] neg_ch);
        t_coord      p;
        logic [20:0] rem;
        logic [44:0] quo;
        rem       = 21'({s.min, 2'b00}) + 21'(s.frac);
        quo       = {24'b0, rem} * {21'b0, DIV6_RECIP};
        p.deg_e7  = 34'({24'b0, s.deg} * {11'b0, DEG_SCALE});
        p.min_e7  = 25'({18'b0, s.min} * {7'b0, MIN_SCALE});
        p.rest_e7 = quo[41:24];
        p.point   = s.point;
        p.neg     = (h.len == 2'd1) && (h.ch == neg_ch);
        p.hemi    = h.ch;
        return p;
    endfunction

    function automatic logic [33:0] magnitude(input t_coord p, input logic [33:0] limit);
        logic [33:0] sum;
        logic [33:0] mag;
        sum = p.deg_e7 + 34'(p.min_e7) + 34'(p.rest_e7);
        mag = (sum > limit) ? limit : sum;
        if (!p.point) mag = '0;
        return p.neg ? (34'd0 - mag) : mag;
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign p_free   = !r_p_valid || out_free;
    assign o_ready  = p_free;
    assign accept   = i_valid && p_free;
    assign hit      = accept && i_byte_in == CH_LF && r_hdr_ok && r_hdr_cnt == HEADER_LEN;

    always_comb begin
        n_field   = r_field;
        n_hdr_cnt = r_hdr_cnt;
        n_hdr_ok  = r_hdr_ok;
        n_num     = r_num;
        n_hemi    = r_hemi;
        if (accept) begin
            if (i_byte_in == CH_LF) begin
                n_field   = '0;
                n_hdr_cnt = '0;
                n_hdr_ok  = 1'b1;
                n_num[0]  = '0;
                n_num[1]  = '0;
                n_hemi[0] = '0;
                n_hemi[1] = '0;
            end else if (i_byte_in == CH_COMMA) begin
                if (r_field != FIELD_MAX) n_field = r_field + 5'd1;
            end else begin
                case (r_field)
                    FIELD_HEADER: begin
                        if (r_hdr_cnt >= HEADER_LEN || i_byte_in != header_char(r_hdr_cnt)) begin
                            n_hdr_ok = 1'b0;
                        end
                        if (r_hdr_cnt != HEADER_SAT) n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end
                    FIELD_LAT_NUM: n_num[0]  = take_char(r_num[0], i_byte_in);
                    FIELD_LON_NUM: n_num[1]  = take_char(r_num[1], i_byte_in);
                    FIELD_LAT_HEM: n_hemi[0] = take_hemi(r_hemi[0], i_byte_in);
                    FIELD_LON_HEM: n_hemi[1] = take_hemi(r_hemi[1], i_byte_in);
                    default: ;
                endcase
            end
        end
    end

    assign n_p[0] = make_coord(r_num[0], r_hemi[0], CH_SOUTH);
    assign n_p[1] = make_coord(r_num[1], r_hemi[1], CH_WEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field     <= '0;
            r_hdr_cnt   <= '0;
            r_hdr_ok    <= 1'b1;
            r_num[0]    <= '0;
            r_num[1]    <= '0;
            r_hemi[0]   <= '0;
            r_hemi[1]   <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_field   <= n_field;
            r_hdr_cnt <= n_hdr_cnt;
            r_hdr_ok  <= n_hdr_ok;
            r_num     <= n_num;
            r_hemi    <= n_hemi;
            if (p_free) r_p_valid <= hit;
            if (out_free) r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_p <= n_p;
        end
        if (out_free && r_p_valid) begin
            r_lat      <= 31'(magnitude(r_p[0], LAT_LIMIT));
            r_lon      <= 32'(magnitude(r_p[1], LON_LIMIT));
            r_lat_hemi <= r_p[0].hemi;
            r_lon_hemi <= r_p[1].hemi;
            r_lat_pt   <= r_p[0].point;
            r_lon_pt   <= r_p[1].point;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_latitude_e7    = r_lat;
    assign o_longitude_e7   = r_lon;
    assign o_lat_hemisphere = r_lat_hemi;
    assign o_lon_hemisphere = r_lon_hemi;
    assign o_lat_has_point  = r_lat_pt;
    assign o_lon_has_point  = r_lon_pt;

endmodule

/* src/ngga_checker.sv */
// ngga_checker: port-level assertions for the gga position parser, bound to the top level
module ngga_checker
    import ngga_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [7:0]         i_byte_in,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [30:0] o_latitude_e7,
    input logic signed [31:0] o_longitude_e7,
    input logic [7:0]         o_lat_hemisphere,
    input logic [7:0]         o_lon_hemisphere,
    input logic               o_lat_has_point,
    input logic               o_lon_has_point
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_latitude_e7) && $stable(o_longitude_e7))
        else $error("result word changed while stalled");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_latitude_e7 >= -31'sd900000000 && o_latitude_e7 <= 31'sd900000000)
        else $error("latitude out of range");

    a_lon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_longitude_e7 >= -32'sd1800000000 && o_longitude_e7 <= 32'sd1800000000)
        else $error("longitude out of range");

    // no point means no value
    a_no_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_lat_has_point || !o_lon_has_point) |->
        (o_lat_has_point || o_latitude_e7 == 31'sd0) &&
        (o_lon_has_point || o_longitude_e7 == 32'sd0))
        else $error("coordinate without point is nonzero");

    // a new result word needs a line feed accepted earlier
    a_result_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_byte_in == CH_LF, 2))
        else $error("result without a line feed");

endmodule

bind nmea_gga_position_parser_core ngga_checker u_ngga_checker (.*);

/* sim/tb_top.sv */
// tb_top: self-checking testbench for the nmea gga position parser core
`timescale 1ns / 1ps

module tb_top;
    import ngga_pkg::*;

    localparam int FRAC_DIGITS = 4;
    localparam int WHOLE_MAX = 131071;
    localparam longint unsigned LAT_MAX_E7 = 900000000;
    localparam longint unsigned LON_MAX_E7 = 1800000000;
    localparam logic [47:0] GGA_TAG = "$GPGGA";
    localparam logic [7:0] CH_NORTH = "N";
    localparam logic [7:0] CH_EAST = "E";
    localparam logic [7:0] CH_DASH = "-";
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam int RANDOM_CHARS = 800;
    localparam int MIN_FIX_LINES = 12;
    localparam int HOLD_AT = 900;
    localparam int HOLD_CYCLES = 700;
    localparam int MID_DRAIN_AT = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [30:0] lat;
        logic [31:0] lon;
        logic [7:0]  lat_hem;
        logic [7:0]  lon_hem;
        logic        lat_pt;
        logic        lon_pt;
    } t_gga_fix;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [7:0]        i_byte_in = 8'h00;
    logic              i_ready = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic signed [30:0] o_latitude_e7;
    logic signed [31:0] o_longitude_e7;
    logic [7:0]        o_lat_hemisphere;
    logic [7:0]        o_lon_hemisphere;
    logic              o_lat_has_point;
    logic              o_lon_has_point;

    nmea_gga_position_parser_core #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_byte_in(i_byte_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_latitude_e7(o_latitude_e7),
        .o_longitude_e7(o_longitude_e7),
        .o_lat_hemisphere(o_lat_hemisphere),
        .o_lon_hemisphere(o_lon_hemisphere),
        .o_lat_has_point(o_lat_has_point),
        .o_lon_has_point(o_lon_has_point)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sentence state of the line parser, index 0 latitude, 1 longitude
    logic [4:0]  ln_field;
    logic [2:0]  ln_hdr_cnt;
    logic        ln_hdr_ok;
    logic [16:0] ln_whole [2];
    logic [19:0] ln_frac [2];
    logic [2:0]  ln_frac_cnt [2];
    logic        ln_point [2];
    logic        ln_stopped [2];
    logic [7:0]  ln_hem_ch [2];
    logic [1:0]  ln_hem_len [2];

    t_gga_fix     fix_queue [$];
    logic [7:0]   line_chars [$];
    int           drain_at [$];
    int           total_chars = 0;
    int           chars_taken = 0;
    int           fix_lines = 0;
    int           err_count = 0;
    int           cycle_count = 0;

    function automatic void clear_sentence();
        ln_field = '0;
        ln_hdr_cnt = '0;
        ln_hdr_ok = 1'b1;
        for (int k = 0; k < 2; k++) begin
            ln_whole[k] = '0;
            ln_frac[k] = '0;
            ln_frac_cnt[k] = '0;
            ln_point[k] = 1'b0;
            ln_stopped[k] = 1'b0;
            ln_hem_ch[k] = '0;
            ln_hem_len[k] = '0;
        end
    endfunction

    function automatic void take_number_char(int k, logic [7:0] c);
        int unsigned w;
        if (c == CH_POINT && !ln_point[k]) begin
            ln_point[k] = 1'b1;
        end else if (!ln_stopped[k]) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!ln_point[k]) begin
                    w = ln_whole[k] * 10 + (c - CH_ZERO);
                    ln_whole[k] = 17'((w > WHOLE_MAX) ? WHOLE_MAX : w);
                end else if (ln_frac_cnt[k] < FRAC_DIGITS) begin
                    ln_frac[k] = 20'(ln_frac[k] * 10 + (c - CH_ZERO));
                    ln_frac_cnt[k] = 3'(ln_frac_cnt[k] + 1);
                end
            end else begin
                ln_stopped[k] = 1'b1;
            end
        end
    endfunction

    // degrees plus minutes/60 in 1e-7 degree, truncated, saturated, then signed
    function automatic logic [31:0] coord_e7(int k, logic [7:0] neg_ch,
                                             longint unsigned limit);
        longint unsigned scale = 1;
        longint unsigned frac;
        longint unsigned whole;
        longint unsigned mins;
        longint unsigned mag;
        if (!ln_point[k])
            return '0;
        for (int i = 0; i < FRAC_DIGITS; i++)
            scale = scale * 10;
        frac = ln_frac[k];
        for (int i = ln_frac_cnt[k]; i < FRAC_DIGITS; i++)
            frac = frac * 10;
        whole = ln_whole[k];
        mins = (whole % 100) * scale + frac;
        mag = (whole / 100) * 64'd10000000 + (mins * 64'd10000000) / (64'd60 * scale);
        if (mag > limit)
            mag = limit;
        if (ln_hem_len[k] == 2'd1 && ln_hem_ch[k] == neg_ch)
            mag = 64'd0 - mag;
        return mag[31:0];
    endfunction

    function automatic bit parse_gga_char(logic [7:0] c, output t_gga_fix fix);
        bit hit;
        logic [31:0] lat;
        fix = '0;
        hit = 1'b0;
        if (c == CH_LF) begin
            hit = ln_hdr_ok && ln_hdr_cnt == HEADER_LEN;
            if (hit) begin
                lat = coord_e7(0, CH_SOUTH, LAT_MAX_E7);
                fix.lat = lat[30:0];
                fix.lon = coord_e7(1, CH_WEST, LON_MAX_E7);
                fix.lat_hem = ln_hem_ch[0];
                fix.lon_hem = ln_hem_ch[1];
                fix.lat_pt = ln_point[0];
                fix.lon_pt = ln_point[1];
            end
            clear_sentence();
        end else if (c == CH_COMMA) begin
            if (ln_field < FIELD_MAX)
                ln_field = 5'(ln_field + 1);
        end else begin
            case (ln_field)
                FIELD_HEADER: begin
                    if (ln_hdr_cnt >= HEADER_LEN || c != GGA_TAG[47 - 8 * ln_hdr_cnt -: 8])
                        ln_hdr_ok = 1'b0;
                    if (ln_hdr_cnt < HEADER_SAT)
                        ln_hdr_cnt = 3'(ln_hdr_cnt + 1);
                end
                FIELD_LAT_NUM: take_number_char(0, c);
                FIELD_LON_NUM: take_number_char(1, c);
                FIELD_LAT_HEM, FIELD_LON_HEM: begin
                    if (ln_hem_len[ln_field == FIELD_LON_HEM] == 2'd0)
                        ln_hem_ch[ln_field == FIELD_LON_HEM] = c;
                    if (ln_hem_len[ln_field == FIELD_LON_HEM] < 2'd3)
                        ln_hem_len[ln_field == FIELD_LON_HEM] =
                            2'(ln_hem_len[ln_field == FIELD_LON_HEM] + 1);
                end
                default: ;
            endcase
        end
        return hit;
    endfunction

    // stimulus construction
    function automatic void add_byte(logic [7:0] b);
        line_chars.push_back(b);
        total_chars++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_line(string s);
        add_text(s);
        add_byte(CH_LF);
    endfunction

    function automatic void mark_drain();
        drain_at.push_back(total_chars);
    endfunction

    function automatic void put_digits(int n);
        for (int i = 0; i < n; i++)
            add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] field_char(bit any_code);
        logic [7:0] b;
        do
            b = 8'(any_code ? $urandom_range(0, 255) : $urandom_range(8'h20, 8'h7e));
        while (b == CH_COMMA || b == CH_LF);
        return b;
    endfunction

    function automatic void put_number(int k);
        if ($urandom_range(0, 9) < 6) begin
            if (k == 0)
                add_text($sformatf("%02d%02d", $urandom_range(0, 90), $urandom_range(0, 59)));
            else
                add_text($sformatf("%03d%02d", $urandom_range(0, 180), $urandom_range(0, 59)));
        end else begin
            put_digits($urandom_range(0, 9));
        end
        if ($urandom_range(0, 9) != 0) begin
            add_byte(CH_POINT);
            put_digits($urandom_range(0, 1) ? FRAC_DIGITS : $urandom_range(0, 8));
        end
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: add_byte(CH_POINT);
                1: add_byte(CH_DASH);
                2: add_byte(CH_CR);
                default: add_byte(field_char(1'b1));
            endcase
            put_digits($urandom_range(0, 3));
        end
    endfunction

    function automatic void put_hemi(int k);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            if (k == 0)
                add_byte($urandom_range(0, 1) ? CH_SOUTH : CH_NORTH);
            else
                add_byte($urandom_range(0, 1) ? CH_WEST : CH_EAST);
        end else if (r == 8) begin
            add_byte(k == 0 ? CH_SOUTH : CH_WEST);
            for (int i = $urandom_range(1, 3); i > 0; i--)
                add_byte(field_char(1'b0));
        end else if (r == 9) begin
            for (int i = $urandom_range(1, 4); i > 0; i--)
                add_byte(field_char(1'b1));
        end
    endfunction

    function automatic void put_gga_line(bit good_hdr);
        int last_field;
        int n_extra;
        if (good_hdr) begin
            add_text("$GPGGA");
            fix_lines++;
        end else begin
            case ($urandom_range(0, 6))
                0: add_text("$GPGG");
                1: add_text("$GPGGAX");
                2: add_text("$GPRMC");
                3: add_text("$GPGGA$GPGGA");
                4: add_text("$gpgga");
                5: ;
                default: begin
                    add_text("$GPGG");
                    add_byte(field_char(1'b1));
                end
            endcase
        end
        last_field = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5;
        for (int f = 1; f <= last_field; f++) begin
            add_byte(CH_COMMA);
            case (f)
                1: begin
                    put_digits($urandom_range(0, 6));
                    if ($urandom_range(0, 1)) begin
                        add_byte(CH_POINT);
                        put_digits(2);
                    end
                end
                2: put_number(0);
                3: put_hemi(0);
                4: put_number(1);
                default: put_hemi(1);
            endcase
        end
        if (last_field == 5) begin
            n_extra = ($urandom_range(0, 29) == 0) ? $urandom_range(26, 40) : $urandom_range(0, 9);
            for (int i = 0; i < n_extra; i++) begin
                add_byte(CH_COMMA);
                for (int j = $urandom_range(0, 4); j > 0; j--)
                    add_byte(field_char(1'b0));
            end
        end
        if ($urandom_range(0, 2) == 0)
            add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // sender: bursts of random length with random gaps, pauses at drain marks
    int  next_idx = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic draining = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_byte_in <= 8'h00;
            draining <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (draining) begin
                if (fix_queue.size() == 0)
                    draining <= 1'b0;
                i_valid <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (drain_at.size() != 0 && drain_at[0] == next_idx) begin
                void'(drain_at.pop_front());
                draining <= 1'b1;
                i_valid <= 1'b0;
            end else if (line_chars.size() != 0) begin
                i_valid <= 1'b1;
                i_byte_in <= line_chars.pop_front();
                next_idx++;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall rate changes per window, one long hold-off
    int  words_seen = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  window_left = 0;
    int  stall_pct = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                words_seen++;
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && words_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                if (window_left == 0) begin
                    window_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end else begin
                    window_left--;
                end
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result check first, then prediction of the word taken at this edge
    always @(posedge i_clk) begin : monitor
        t_gga_fix got;
        t_gga_fix want;
        bit       bad;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_latitude_e7, o_longitude_e7, o_lat_hemisphere, o_lon_hemisphere,
                        o_lat_has_point, o_lon_has_point};
                if (fix_queue.size() == 0) begin
                    if (err_count < 10)
                        $display("unexpected result: lat %0d lon %0d hem %h/%h pt %b/%b",
                                 $signed(got.lat), $signed(got.lon), got.lat_hem,
                                 got.lon_hem, got.lat_pt, got.lon_pt);
                    err_count++;
                end else begin
                    want = fix_queue.pop_front();
                    bad = (got.lat !== want.lat) || (got.lon !== want.lon)
                        || (got.lat_hem !== want.lat_hem) || (got.lon_hem !== want.lon_hem)
                        || (got.lat_pt !== want.lat_pt) || (got.lon_pt !== want.lon_pt);
                    if (bad) begin
                        if (err_count < 10) begin
                            $display("mismatch: exp lat %0d lon %0d hem %h/%h pt %b/%b",
                                     $signed(want.lat), $signed(want.lon), want.lat_hem,
                                     want.lon_hem, want.lat_pt, want.lon_pt);
                            $display("          got lat %0d lon %0d hem %h/%h pt %b/%b",
                                     $signed(got.lat), $signed(got.lon), got.lat_hem,
                                     got.lon_hem, got.lat_pt, got.lon_pt);
                        end
                        err_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                chars_taken++;
                if (parse_gga_char(i_byte_in, want))
                    fix_queue.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int directed_chars;
        int r;
        bit mid_drain_done;
        clear_sentence();
        mid_drain_done = 1'b0;

        add_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        add_line("$GPGGA,,3351.1234,S,15112.5678,W");
        add_line("$GPGGA,,9000.0000,S,18000.0000,W");
        add_line("$GPGGA,,9959.9999999,N,99999999.99999,E");
        add_line("$GPGGA,,0000.0000,N,00000.0000,E");
        add_line("$GPGGA,,4807,S,01131,W");
        add_line("$GPGGA,,5.5,S,7.25,W");
        add_line("$GPGGA,,1275.5,N,00099.9,E");
        add_line("$GPGGA,,48a07.03.8,N,011-31.0,E");
        add_line("$GPGGA,,1.5,SS,1.5,w");
        add_line("$GPGGA,,1.5,,1.5,");
        add_line("$GPGGA,,.5,S,.,W");
        add_line("$GPGGA,,12.5");
        add_line("$GPGGA");
        add_line("$GPGGAA,,1.0,S");
        add_line("$GPRMC,,1.0,S");
        add_line("GPGGA");
        add_line("");
        // field counter saturation
        add_text("$GPGGA,,1.0,S,2.0,W");
        for (int i = 0; i < 30; i++)
            add_byte(CH_COMMA);
        add_line("x");
        // nul and carriage return as plain characters
        add_text("$GPGGA,,12");
        add_byte(CH_NUL);
        add_text("34.5,S,1.0,W");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_line("$GPGGA,,1.0,S");
        add_text("$GPGGA,,1.0,");
        add_byte(8'hff);
        add_text(",1.0,");
        add_byte(8'h80);
        add_byte(CH_LF);

        mark_drain();
        directed_chars = total_chars;
        while (total_chars - directed_chars < RANDOM_CHARS || fix_lines < MIN_FIX_LINES) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                put_gga_line(1'b1);
            end else if (r < 88) begin
                put_gga_line(1'b0);
            end else if (r < 95) begin
                for (int i = $urandom_range(1, 40); i > 0; i--)
                    add_byte(8'($urandom_range(0, 255)));
                add_byte(CH_LF);
            end else begin
                add_text("$GPGGA,,");
                put_number(0);
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    add_byte(field_char(1'b1));
                add_byte(CH_LF);
            end
            if (!mid_drain_done && total_chars - directed_chars > MID_DRAIN_AT) begin
                mid_drain_done = 1'b1;
                mark_drain();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken < total_chars)
            @(posedge i_clk);
        while (fix_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && fix_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
